FILE: rtl/rms_pkg.sv
// shared types and codes for the relativistic momentum step block
`timescale 1ns / 1ps

package rms_pkg;

	localparam logic [1:0] MODE_FORCE = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_SEED  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_GUARD    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [1:0] REG_REST_MASS   = 2'd0;
	localparam logic [1:0] REG_LIGHT_SPEED = 2'd1;
	localparam logic [1:0] REG_BETA_LIMIT  = 2'd2;

	localparam logic [31:0] REST_MASS_RESET   = 32'h0001_0000;
	localparam logic [31:0] LIGHT_SPEED_RESET = 32'h0001_0000;
	localparam logic [15:0] BETA_LIMIT_RESET  = 16'hFFFF;
	localparam logic [31:0] ONE_Q16           = 32'h0001_0000;

	localparam logic [1:0] LANE_FIRST = 2'd0;
	localparam logic [1:0] LANE_LAST  = 2'd2;

	typedef enum logic [5:0] {
		OP_DISPATCH, OP_GUARD, OP_LOAD,
		OP_F_MUL, OP_F_ADD, OP_F_COMMIT,
		OP_S_MUL, OP_S_ACC, OP_S_ROOT, OP_S_SPEED, OP_S_BDIV, OP_S_BETA,
		OP_S_BSQ, OP_S_OROOT, OP_S_GDIV, OP_S_MG, OP_S_MGL, OP_S_MGH,
		OP_S_MGA, OP_S_M, OP_S_PMUL, OP_S_PDIV, OP_S_PSET,
		OP_O_ZERO, OP_O_MC, OP_O_Q0, OP_O_Q1, OP_O_Q2, OP_O_Q3, OP_O_Q4,
		OP_O_PMUL, OP_O_PACC, OP_O_EROOT, OP_O_VMUL, OP_O_VDIV, OP_O_VSET,
		OP_O_GDIV, OP_O_GSET, OP_O_K0, OP_O_K1, OP_O_K2, OP_O_KDIV, OP_O_KSET
	} op_t;

	typedef struct packed {
		logic       issue;
		logic       capture;
		logic       out_load;
		op_t        op;
		logic [1:0] lane;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       mass_zero;
		logic       dt_zero;
		logic       root_zero;
		logic       busy;
	} stat_t;

endpackage

FILE: rtl/rms_div.sv
// radix-2 restoring divider, 128 by 64 bits, saturating quotient
`timescale 1ns / 1ps

module rms_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic [63:0]  quot,
	output logic         busy
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] lo_q;
	logic [63:0] den_q;
	logic [63:0] quot_q;
	logic [64:0] sh;
	logic        ge;
	logic        sat;

	assign sat = (den == 64'd0) || (num[127:64] >= den);
	assign sh = {rem_q, lo_q[63]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= !sat;
			cnt_q  <= 6'd63;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[127:64];
			lo_q  <= num[63:0];
			den_q <= den;
			if (sat) begin
				quot_q <= '1;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? 64'(sh - {1'b0, den_q}) : sh[63:0];
			lo_q   <= {lo_q[62:0], 1'b0};
			quot_q <= {quot_q[62:0], ge};
		end
	end

	assign quot = quot_q;
	assign busy = busy_q;

endmodule

FILE: rtl/rms_sqrt.sv
// bit-serial integer square root, 128-bit radicand, two bits per cycle
`timescale 1ns / 1ps

module rms_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] rad,
	output logic [63:0]  root,
	output logic         busy
);

	logic         busy_q;
	logic [5:0]   cnt_q;
	logic [127:0] rad_q;
	logic [64:0]  rem_q;
	logic [63:0]  root_q;
	logic [66:0]  r2;
	logic [66:0]  trial;
	logic         ge;

	assign r2    = {rem_q, rad_q[127:126]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd63;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= 65'd0;
			root_q <= 64'd0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[125:0], 2'b00};
			rem_q  <= ge ? 65'(r2 - trial) : r2[64:0];
			root_q <= {root_q[62:0], ge};
		end
	end

	assign root = root_q;
	assign busy = busy_q;

endmodule

FILE: rtl/rms_datapath.sv
// datapath: config, momentum state, shared multiplier, divider, root unit, result registers
`timescale 1ns / 1ps

module rms_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         mode,
	input  logic signed [31:0] operand_x,
	input  logic signed [31:0] operand_y,
	input  logic signed [31:0] operand_z,
	input  logic [31:0]        time_step,
	input  rms_pkg::cmd_t      cmd,
	output rms_pkg::stat_t     stat,
	output logic signed [31:0] momentum_out_x,
	output logic signed [31:0] momentum_out_y,
	output logic signed [31:0] momentum_out_z,
	output logic signed [31:0] velocity_x,
	output logic signed [31:0] velocity_y,
	output logic signed [31:0] velocity_z,
	output logic [31:0]        lorentz_factor,
	output logic [47:0]        kinetic_energy,
	output logic [1:0]         status
);

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? 32'(-v) : 32'(v);
	endfunction

	logic [31:0]        rest_mass_q;
	logic [31:0]        light_speed_q;
	logic [15:0]        beta_limit_q;
	logic [1:0]         mode_q;
	logic signed [31:0] opnd_q [3];
	logic [31:0]        dt_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] np_q [3];
	logic               ovf_q;
	logic [63:0]        prod_q;
	logic [127:0]       acc_q;
	logic [63:0]        p2_q;
	logic [63:0]        mc_q;
	logic [32:0]        speed_q;
	logic [15:0]        beta_q;
	logic [31:0]        bs_q;
	logic [15:0]        mghi_q;
	logic [30:0]        m_q;
	logic signed [31:0] vel_q [3];
	logic [31:0]        gamma_q;
	logic [47:0]        ke_q;
	logic [1:0]         status_q;
	logic signed [31:0] out_p_q [3];
	logic signed [31:0] out_v_q [3];
	logic [31:0]        out_gamma_q;
	logic [47:0]        out_ke_q;
	logic [1:0]         out_status_q;

	logic [31:0]        c_eff;
	logic [31:0]        opnd_mag;
	logic [31:0]        mom_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic               mul_en;
	logic               div_start;
	logic [127:0]       div_num;
	logic [63:0]        div_den;
	logic [63:0]        div_q;
	logic               div_busy;
	logic               sqrt_start;
	logic [127:0]       sqrt_rad;
	logic [63:0]        sqrt_root;
	logic               sqrt_busy;
	logic [32:0]        omb2;
	logic [63:0]        ke_den;
	logic signed [64:0] f_sp;
	logic signed [49:0] f_np;
	logic               f_ovf;
	logic [31:0]        vq;
	logic [62:0]        kq;

	assign c_eff    = (light_speed_q == 32'd0) ? 32'd1 : light_speed_q;
	assign opnd_mag = mag32(opnd_q[cmd.lane]);
	assign mom_mag  = mag32(p_q[cmd.lane]);
	assign omb2     = 33'h1_0000_0000 - prod_q[32:0];
	assign ke_den   = {1'b0, sqrt_root[63:1]} + {1'b0, mc_q[63:1]}
		+ {63'd0, sqrt_root[0] & mc_q[0]};
	assign f_sp     = opnd_q[cmd.lane][31] ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
	assign f_np     = 50'(p_q[cmd.lane]) + 50'($signed(f_sp[64:16]));
	assign f_ovf    = !((&f_np[49:31]) || !(|f_np[49:31]));
	assign vq       = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
	assign kq       = div_q[63:1];

	always_comb begin
		mul_a  = 32'd0;
		mul_b  = 32'd0;
		mul_en = 1'b1;
		case (cmd.op)
			rms_pkg::OP_F_MUL:  begin mul_a = opnd_mag;             mul_b = dt_q;            end
			rms_pkg::OP_S_MUL:  begin mul_a = opnd_mag;             mul_b = opnd_mag;        end
			rms_pkg::OP_S_BSQ:  begin mul_a = {16'd0, beta_q};      mul_b = {16'd0, beta_q}; end
			rms_pkg::OP_S_OROOT: begin mul_a = {16'd0, beta_q};     mul_b = c_eff;           end
			rms_pkg::OP_S_MG:   begin mul_a = rest_mass_q;          mul_b = div_q[31:0];     end
			rms_pkg::OP_S_MGL:  begin mul_a = prod_q[47:16];        mul_b = bs_q;            end
			rms_pkg::OP_S_MGH:  begin mul_a = {16'd0, mghi_q};      mul_b = bs_q;            end
			rms_pkg::OP_S_PMUL: begin mul_a = opnd_mag;             mul_b = {1'b0, m_q};     end
			rms_pkg::OP_O_MC:   begin mul_a = rest_mass_q;          mul_b = c_eff;           end
			rms_pkg::OP_O_Q0:   begin mul_a = prod_q[31:0];         mul_b = prod_q[31:0];    end
			rms_pkg::OP_O_Q1:   begin mul_a = mc_q[31:0];           mul_b = mc_q[63:32];     end
			rms_pkg::OP_O_Q2:   begin mul_a = mc_q[63:32];          mul_b = mc_q[31:0];      end
			rms_pkg::OP_O_Q3:   begin mul_a = mc_q[63:32];          mul_b = mc_q[63:32];     end
			rms_pkg::OP_O_PMUL: begin mul_a = mom_mag;              mul_b = mom_mag;         end
			rms_pkg::OP_O_VMUL: begin mul_a = mom_mag;              mul_b = c_eff;           end
			rms_pkg::OP_O_K0:   begin mul_a = p2_q[31:0];           mul_b = c_eff;           end
			rms_pkg::OP_O_K1:   begin mul_a = p2_q[63:32];          mul_b = c_eff;           end
			default:            mul_en = 1'b0;
		endcase
	end

	always_comb begin
		div_start  = cmd.issue;
		div_num    = {64'd0, prod_q};
		div_den    = sqrt_root;
		sqrt_start = cmd.issue;
		sqrt_rad   = acc_q;
		case (cmd.op)
			rms_pkg::OP_S_BDIV: begin
				div_num = {79'd0, speed_q, 16'd0};
				div_den = {32'd0, c_eff};
			end
			rms_pkg::OP_S_GDIV: div_num = 128'd1 << 47;
			rms_pkg::OP_S_PDIV: div_den = {31'd0, speed_q};
			rms_pkg::OP_O_VDIV: div_num = {48'd0, prod_q, 16'd0};
			rms_pkg::OP_O_GDIV: begin
				div_num = {48'd0, sqrt_root, 16'd0};
				div_den = mc_q;
			end
			rms_pkg::OP_O_KDIV: begin
				div_num = acc_q;
				div_den = ke_den;
			end
			default: div_start = 1'b0;
		endcase
		case (cmd.op)
			rms_pkg::OP_S_ROOT, rms_pkg::OP_O_EROOT: ;
			rms_pkg::OP_S_OROOT: sqrt_rad = {65'd0, omb2, 30'd0};
			default: sqrt_start = 1'b0;
		endcase
	end

	rms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_q),
		.busy   (div_busy)
	);

	rms_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sqrt_rad),
		.root   (sqrt_root),
		.busy   (sqrt_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_mass_q   <= rms_pkg::REST_MASS_RESET;
			light_speed_q <= rms_pkg::LIGHT_SPEED_RESET;
			beta_limit_q  <= rms_pkg::BETA_LIMIT_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				rms_pkg::REG_REST_MASS:   rest_mass_q   <= cfg_data;
				rms_pkg::REG_LIGHT_SPEED: light_speed_q <= cfg_data;
				rms_pkg::REG_BETA_LIMIT:  beta_limit_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// momentum state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q[0] <= 32'sd0;
			p_q[1] <= 32'sd0;
			p_q[2] <= 32'sd0;
		end else if (cmd.issue) begin
			case (cmd.op)
				rms_pkg::OP_LOAD: p_q <= opnd_q;
				rms_pkg::OP_F_COMMIT: begin
					if (!ovf_q) begin
						p_q <= np_q;
					end
				end
				rms_pkg::OP_S_SPEED: begin
					if (sqrt_root == 64'd0) begin
						p_q[0] <= 32'sd0;
						p_q[1] <= 32'sd0;
						p_q[2] <= 32'sd0;
					end
				end
				rms_pkg::OP_S_PSET: begin
					p_q[cmd.lane] <= opnd_q[cmd.lane][31] ? -$signed(div_q[31:0])
						: $signed(div_q[31:0]);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= mode;
			opnd_q[0] <= operand_x;
			opnd_q[1] <= operand_y;
			opnd_q[2] <= operand_z;
			dt_q      <= time_step;
		end
		if (mul_en && cmd.issue) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.issue) begin
			case (cmd.op)
				rms_pkg::OP_DISPATCH: begin
					status_q <= rms_pkg::STATUS_OK;
					ovf_q    <= 1'b0;
				end
				rms_pkg::OP_GUARD: status_q <= rms_pkg::STATUS_GUARD;
				rms_pkg::OP_F_ADD: begin
					np_q[cmd.lane] <= f_np[31:0];
					ovf_q          <= ovf_q | f_ovf;
				end
				rms_pkg::OP_F_COMMIT: begin
					if (ovf_q) begin
						status_q <= rms_pkg::STATUS_OVERFLOW;
					end
				end
				rms_pkg::OP_S_ACC: begin
					acc_q <= ((cmd.lane == rms_pkg::LANE_FIRST) ? 128'd0 : acc_q)
						+ {64'd0, prod_q};
				end
				rms_pkg::OP_S_SPEED: speed_q <= sqrt_root[32:0];
				rms_pkg::OP_S_BETA: begin
					if (div_q >= {48'd0, beta_limit_q}) begin
						beta_q <= (beta_limit_q == 16'd0) ? 16'd0 : beta_limit_q - 16'd1;
					end else begin
						beta_q <= div_q[15:0];
					end
				end
				rms_pkg::OP_S_GDIV: bs_q   <= prod_q[47:16];
				rms_pkg::OP_S_MGL:  mghi_q <= prod_q[63:48];
				rms_pkg::OP_S_MGH:  acc_q  <= {64'd0, prod_q};
				rms_pkg::OP_S_MGA:  acc_q  <= acc_q + {32'd0, prod_q, 32'd0};
				rms_pkg::OP_S_M: begin
					m_q <= (acc_q > 128'h7FFF_FFFF_FFFF) ? 31'h7FFF_FFFF : acc_q[46:16];
				end
				rms_pkg::OP_O_ZERO: begin
					vel_q[0] <= 32'sd0;
					vel_q[1] <= 32'sd0;
					vel_q[2] <= 32'sd0;
					gamma_q  <= rms_pkg::ONE_Q16;
					ke_q     <= 48'd0;
				end
				rms_pkg::OP_O_Q0: mc_q  <= prod_q;
				rms_pkg::OP_O_Q1, rms_pkg::OP_O_K1: acc_q <= {64'd0, prod_q};
				rms_pkg::OP_O_Q2, rms_pkg::OP_O_Q3, rms_pkg::OP_O_K2: begin
					acc_q <= acc_q + {32'd0, prod_q, 32'd0};
				end
				rms_pkg::OP_O_Q4: acc_q <= acc_q + {prod_q, 64'd0};
				rms_pkg::OP_O_PACC: begin
					acc_q <= acc_q + {32'd0, prod_q, 32'd0};
					p2_q  <= ((cmd.lane == rms_pkg::LANE_FIRST) ? 64'd0 : p2_q) + prod_q;
				end
				rms_pkg::OP_O_VSET: begin
					vel_q[cmd.lane] <= p_q[cmd.lane][31] ? -$signed(vq) : $signed(vq);
				end
				rms_pkg::OP_O_GSET: begin
					gamma_q <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
				end
				rms_pkg::OP_O_KSET: begin
					ke_q <= (kq > 63'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : kq[47:0];
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			out_p_q      <= p_q;
			out_v_q      <= vel_q;
			out_gamma_q  <= gamma_q;
			out_ke_q     <= ke_q;
			out_status_q <= status_q;
		end
	end

	assign stat.mode      = mode_q;
	assign stat.mass_zero = rest_mass_q == 32'd0;
	assign stat.dt_zero   = dt_q == 32'd0;
	assign stat.root_zero = sqrt_root == 64'd0;
	assign stat.busy      = div_busy | sqrt_busy;

	assign momentum_out_x = out_p_q[0];
	assign momentum_out_y = out_p_q[1];
	assign momentum_out_z = out_p_q[2];
	assign velocity_x     = out_v_q[0];
	assign velocity_y     = out_v_q[1];
	assign velocity_z     = out_v_q[2];
	assign lorentz_factor = out_gamma_q;
	assign kinetic_energy = out_ke_q;
	assign status         = out_status_q;

endmodule

FILE: rtl/rms_ctrl.sv
// controller: sequences datapath operations per item and runs both handshakes
`timescale 1ns / 1ps

module rms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  rms_pkg::stat_t stat,
	output rms_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t          state_q;
	rms_pkg::op_t    op_q;
	logic [1:0]      lane_q;
	logic            out_valid_q;
	rms_pkg::op_t    nxt_op;
	rms_pkg::op_t    out_op;
	logic [1:0]      nxt_lane;
	logic            nxt_fin;
	logic            starts;
	logic            capture;
	logic            out_load;
	logic            last;

	assign capture  = in_valid && (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign last     = lane_q == rms_pkg::LANE_LAST;
	assign out_op   = stat.mass_zero ? rms_pkg::OP_O_ZERO : rms_pkg::OP_O_MC;

	always_comb begin
		case (op_q) inside
			rms_pkg::OP_S_ROOT, rms_pkg::OP_S_BDIV, rms_pkg::OP_S_OROOT, rms_pkg::OP_S_GDIV,
			rms_pkg::OP_S_PDIV, rms_pkg::OP_O_EROOT, rms_pkg::OP_O_VDIV, rms_pkg::OP_O_GDIV,
			rms_pkg::OP_O_KDIV: starts = 1'b1;
			default: starts = 1'b0;
		endcase
	end

	always_comb begin
		nxt_op   = rms_pkg::OP_DISPATCH;
		nxt_lane = rms_pkg::LANE_FIRST;
		nxt_fin  = 1'b0;
		case (op_q)
			rms_pkg::OP_DISPATCH: begin
				unique case (stat.mode)
					rms_pkg::MODE_FORCE: nxt_op = (stat.mass_zero || stat.dt_zero)
						? rms_pkg::OP_GUARD : rms_pkg::OP_F_MUL;
					rms_pkg::MODE_LOAD: nxt_op = rms_pkg::OP_LOAD;
					rms_pkg::MODE_SEED: nxt_op = stat.mass_zero
						? rms_pkg::OP_GUARD : rms_pkg::OP_S_MUL;
					default: nxt_op = rms_pkg::OP_GUARD;
				endcase
			end
			rms_pkg::OP_GUARD, rms_pkg::OP_LOAD, rms_pkg::OP_F_COMMIT: nxt_op = out_op;
			rms_pkg::OP_F_MUL: begin
				nxt_op   = rms_pkg::OP_F_ADD;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_F_ADD: begin
				nxt_op   = last ? rms_pkg::OP_F_COMMIT : rms_pkg::OP_F_MUL;
				nxt_lane = last ? rms_pkg::LANE_FIRST : lane_q + 2'd1;
			end
			rms_pkg::OP_S_MUL: begin
				nxt_op   = rms_pkg::OP_S_ACC;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_S_ACC: begin
				nxt_op   = last ? rms_pkg::OP_S_ROOT : rms_pkg::OP_S_MUL;
				nxt_lane = last ? rms_pkg::LANE_FIRST : lane_q + 2'd1;
			end
			rms_pkg::OP_S_ROOT:  nxt_op = rms_pkg::OP_S_SPEED;
			rms_pkg::OP_S_SPEED: nxt_op = stat.root_zero ? out_op : rms_pkg::OP_S_BDIV;
			rms_pkg::OP_S_BDIV:  nxt_op = rms_pkg::OP_S_BETA;
			rms_pkg::OP_S_BETA:  nxt_op = rms_pkg::OP_S_BSQ;
			rms_pkg::OP_S_BSQ:   nxt_op = rms_pkg::OP_S_OROOT;
			rms_pkg::OP_S_OROOT: nxt_op = rms_pkg::OP_S_GDIV;
			rms_pkg::OP_S_GDIV:  nxt_op = rms_pkg::OP_S_MG;
			rms_pkg::OP_S_MG:    nxt_op = rms_pkg::OP_S_MGL;
			rms_pkg::OP_S_MGL:   nxt_op = rms_pkg::OP_S_MGH;
			rms_pkg::OP_S_MGH:   nxt_op = rms_pkg::OP_S_MGA;
			rms_pkg::OP_S_MGA:   nxt_op = rms_pkg::OP_S_M;
			rms_pkg::OP_S_M:     nxt_op = rms_pkg::OP_S_PMUL;
			rms_pkg::OP_S_PMUL: begin
				nxt_op   = rms_pkg::OP_S_PDIV;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_S_PDIV: begin
				nxt_op   = rms_pkg::OP_S_PSET;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_S_PSET: begin
				nxt_op   = last ? out_op : rms_pkg::OP_S_PMUL;
				nxt_lane = last ? rms_pkg::LANE_FIRST : lane_q + 2'd1;
			end
			rms_pkg::OP_O_ZERO: nxt_fin = 1'b1;
			rms_pkg::OP_O_MC:   nxt_op = rms_pkg::OP_O_Q0;
			rms_pkg::OP_O_Q0:   nxt_op = rms_pkg::OP_O_Q1;
			rms_pkg::OP_O_Q1:   nxt_op = rms_pkg::OP_O_Q2;
			rms_pkg::OP_O_Q2:   nxt_op = rms_pkg::OP_O_Q3;
			rms_pkg::OP_O_Q3:   nxt_op = rms_pkg::OP_O_Q4;
			rms_pkg::OP_O_Q4:   nxt_op = rms_pkg::OP_O_PMUL;
			rms_pkg::OP_O_PMUL: begin
				nxt_op   = rms_pkg::OP_O_PACC;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_O_PACC: begin
				nxt_op   = last ? rms_pkg::OP_O_EROOT : rms_pkg::OP_O_PMUL;
				nxt_lane = last ? rms_pkg::LANE_FIRST : lane_q + 2'd1;
			end
			rms_pkg::OP_O_EROOT: nxt_op = rms_pkg::OP_O_VMUL;
			rms_pkg::OP_O_VMUL: begin
				nxt_op   = rms_pkg::OP_O_VDIV;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_O_VDIV: begin
				nxt_op   = rms_pkg::OP_O_VSET;
				nxt_lane = lane_q;
			end
			rms_pkg::OP_O_VSET: begin
				nxt_op   = last ? rms_pkg::OP_O_GDIV : rms_pkg::OP_O_VMUL;
				nxt_lane = last ? rms_pkg::LANE_FIRST : lane_q + 2'd1;
			end
			rms_pkg::OP_O_GDIV: nxt_op = rms_pkg::OP_O_GSET;
			rms_pkg::OP_O_GSET: nxt_op = rms_pkg::OP_O_K0;
			rms_pkg::OP_O_K0:   nxt_op = rms_pkg::OP_O_K1;
			rms_pkg::OP_O_K1:   nxt_op = rms_pkg::OP_O_K2;
			rms_pkg::OP_O_K2:   nxt_op = rms_pkg::OP_O_KDIV;
			rms_pkg::OP_O_KDIV: nxt_op = rms_pkg::OP_O_KSET;
			rms_pkg::OP_O_KSET: nxt_fin = 1'b1;
			default: nxt_fin = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= rms_pkg::OP_DISPATCH;
			lane_q      <= rms_pkg::LANE_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (capture) begin
						op_q    <= rms_pkg::OP_DISPATCH;
						lane_q  <= rms_pkg::LANE_FIRST;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (nxt_fin) begin
						state_q <= ST_DONE;
					end else begin
						op_q    <= nxt_op;
						lane_q  <= nxt_lane;
						state_q <= starts ? ST_WAIT : ST_ISSUE;
					end
				end
				ST_WAIT: begin
					if (!stat.busy) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = state_q == ST_IDLE;
	assign out_valid    = out_valid_q;
	assign cmd.issue    = state_q == ST_ISSUE;
	assign cmd.capture  = capture;
	assign cmd.out_load = out_load;
	assign cmd.op       = op_q;
	assign cmd.lane     = lane_q;

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !stat.busy)
		else $error("arithmetic unit busy while idle");

	a_capture_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> state_q == ST_ISSUE && op_q == rms_pkg::OP_DISPATCH)
		else $error("accepted item not dispatched");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && !out_ready |=> state_q == ST_DONE)
		else $error("finished item dropped while output stalled");

	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> lane_q != 2'd3)
		else $error("lane out of range");

endmodule

FILE: rtl/relativistic_momentum_step.sv
// top level: relativistic momentum step, controller plus datapath
// the shared radix-2 divider and two-bit root unit serve one use at a time
// throughput: one item at a time; the next item is taken once the result sits in the output register
// zero rest mass skips the unit work and sets zero velocity and energy with gamma 1.0
// reset clears momentum to zero and loads mass 1.0, light speed 1.0 and beta limit 65535
`timescale 1ns / 1ps

module relativistic_momentum_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [31:0] operand_x,
	input  logic signed [31:0] operand_y,
	input  logic signed [31:0] operand_z,
	input  logic [31:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] momentum_out_x,
	output logic signed [31:0] momentum_out_y,
	output logic signed [31:0] momentum_out_z,
	output logic signed [31:0] velocity_x,
	output logic signed [31:0] velocity_y,
	output logic signed [31:0] velocity_z,
	output logic [31:0]        lorentz_factor,
	output logic [47:0]        kinetic_energy,
	output logic [1:0]         status
);

	rms_pkg::cmd_t  cmd;
	rms_pkg::stat_t stat;

	rms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rms_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.operand_x      (operand_x),
		.operand_y      (operand_y),
		.operand_z      (operand_z),
		.time_step      (time_step),
		.cmd            (cmd),
		.stat           (stat),
		.momentum_out_x (momentum_out_x),
		.momentum_out_y (momentum_out_y),
		.momentum_out_z (momentum_out_z),
		.velocity_x     (velocity_x),
		.velocity_y     (velocity_y),
		.velocity_z     (velocity_z),
		.lorentz_factor (lorentz_factor),
		.kinetic_energy (kinetic_energy),
		.status         (status)
	);

endmodule
